>>> rtl/instrument_autovibrato_fadeout_defines.svh
// ----------------------------------------------------------------------------
// instrument_autovibrato_fadeout_defines
// Assertion macros shared by the instrument auto-vibrato / fadeout block.
// ----------------------------------------------------------------------------
`ifndef INSTRUMENT_AUTOVIBRATO_FADEOUT_DEFINES_SVH
`define INSTRUMENT_AUTOVIBRATO_FADEOUT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IAF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IAF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iaf_pkg.sv
// ----------------------------------------------------------------------------
// iaf_pkg
// Types, constants and wave helpers of the auto-vibrato / fadeout block.
// ----------------------------------------------------------------------------
package iaf_pkg;

    localparam int OFFSET_W = 13;
    localparam int LEVEL_W  = 16;
    localparam int MAG_W    = 12;
    localparam int PROD_W   = 20;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] FADE_FULL = 16'd32768;

    // register indexes on the config port
    localparam logic [2:0] REG_WAVE_SHAPE = 3'd0;
    localparam logic [2:0] REG_VIB_DEPTH  = 3'd1;
    localparam logic [2:0] REG_VIB_SWEEP  = 3'd2;
    localparam logic [2:0] REG_VIB_RATE   = 3'd3;
    localparam logic [2:0] REG_FADE_RATE  = 3'd4;

    // wave shapes
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_INVSAW = 2'd2;
    localparam logic [1:0] WAVE_SAW    = 2'd3;

    localparam logic [0:0] OP_TICK    = 1'b0;
    localparam logic [0:0] OP_RETRIG  = 1'b1;

    typedef struct packed {
        logic accept;
        logic clear;
        logic ld_mag;
        logic ld_prod;
        logic div_step;
        logic ld_out;
    } cmd_t;

    typedef struct packed {
        logic retrig;
        logic sweep_zero;
        logic out_free;
    } stat_t;

    localparam logic [6:0] QUARTER_SINE [0:64] = '{
        7'd0,  7'd2,  7'd3,  7'd5,  7'd6,  7'd8,  7'd9,  7'd11,
        7'd12, 7'd14, 7'd16, 7'd17, 7'd19, 7'd20, 7'd22, 7'd23,
        7'd24, 7'd26, 7'd27, 7'd29, 7'd30, 7'd32, 7'd33, 7'd34,
        7'd36, 7'd37, 7'd38, 7'd39, 7'd41, 7'd42, 7'd43, 7'd44,
        7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52,
        7'd53, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd58, 7'd59,
        7'd59, 7'd60, 7'd60, 7'd61, 7'd61, 7'd62, 7'd62, 7'd62,
        7'd63, 7'd63, 7'd63, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64,
        7'd64
    };

    // signed wave value, -64..64
    function automatic logic signed [7:0] wave_at(input logic [1:0] shape,
                                                   input logic [7:0] p);
        logic [6:0] mag;
        logic [6:0] ramp;
        logic signed [7:0] w;
        mag  = 7'd0;
        ramp = 7'd0;
        w    = 8'sd0;
        unique case (shape)
            WAVE_SINE: begin
                mag = p[6] ? QUARTER_SINE[7'd64 - {1'b0, p[5:0]}]
                           : QUARTER_SINE[{1'b0, p[5:0]}];
                w = p[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            WAVE_SQUARE: begin
                w = p[7] ? -8'sd64 : 8'sd64;
            end
            WAVE_INVSAW: begin
                ramp = 7'd64 - p[7:1];
                w = $signed({1'b0, ramp}) - 8'sd64;
            end
            WAVE_SAW: begin
                ramp = p[7:1] + 7'd64;
                w = $signed({1'b0, ramp}) - 8'sd64;
            end
            default: w = 8'sd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/instrument_autovibrato_fadeout.sv
// ----------------------------------------------------------------------------
// instrument_autovibrato_fadeout
// Per-tick fadeout and instrument auto-vibrato for one tracker channel.
//
//   channel   dir  tdata fields (low bit up)               other
//   s_        in   key_released, pad                       tuser = opcode
//   m_        out  period_offset[12:0], fade_level[28:13]  -
//   apb       in   5 regs at 4*i: shape, depth, sweep, rate, fade
//
// After the accepting edge the result passes ST_MAG and ST_OUT for a
// retrigger, ST_MAG, ST_PROD and ST_OUT for a tick with sweep 0, and else
// ST_DIV too: the sweep scaling runs through a restoring divider, one quotient
// bit a cycle over the 20-bit product. One item is in flight at a time; the
// next one is taken once the result sits in the output register, which may
// stall on m_tready. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "instrument_autovibrato_fadeout_defines.svh"

module instrument_autovibrato_fadeout (
    input  logic        aclk,
    input  logic        aresetn,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] key_released, [7:1] zero
    input  logic        s_tuser,   // [0] opcode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [12:0] period_offset, [28:13] fade_level
);
    import iaf_pkg::*;

    logic [1:0]  wave_shape_reg;
    logic [3:0]  vib_depth_reg;
    logic [7:0]  vib_sweep_reg;
    logic [5:0]  vib_rate_reg;
    logic [11:0] fade_rate_reg;

    logic [2:0]  reg_idx;
    logic        cfg_wr;

    cmd_t  cmd;
    stat_t stat;

    logic signed [OFFSET_W-1:0] period_offset;
    logic [LEVEL_W-1:0]         fade_level;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_shape_reg <= '0;
            vib_depth_reg  <= '0;
            vib_sweep_reg  <= '0;
            vib_rate_reg   <= '0;
            fade_rate_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WAVE_SHAPE: wave_shape_reg <= pwdata[1:0];
                REG_VIB_DEPTH:  vib_depth_reg  <= pwdata[3:0];
                REG_VIB_SWEEP:  vib_sweep_reg  <= pwdata[7:0];
                REG_VIB_RATE:   vib_rate_reg   <= pwdata[5:0];
                REG_FADE_RATE:  fade_rate_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WAVE_SHAPE: prdata = {30'd0, wave_shape_reg};
            REG_VIB_DEPTH:  prdata = {28'd0, vib_depth_reg};
            REG_VIB_SWEEP:  prdata = {24'd0, vib_sweep_reg};
            REG_VIB_RATE:   prdata = {26'd0, vib_rate_reg};
            REG_FADE_RATE:  prdata = {20'd0, fade_rate_reg};
            default:        prdata = 32'd0;
        endcase
    end

    iaf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iaf_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .in_opcode         (s_tuser),
        .in_key_released   (s_tdata[0]),
        .wave_shape        (wave_shape_reg),
        .vib_depth         (vib_depth_reg),
        .vib_sweep         (vib_sweep_reg),
        .vib_rate          (vib_rate_reg),
        .fade_rate         (fade_rate_reg),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_period_offset (period_offset),
        .out_fade_level    (fade_level)
    );

    assign m_tdata = {3'd0, fade_level, period_offset};

    `IAF_ASSERT_NEXT(a_one_in_flight, aclk, aresetn,
        s_tvalid && s_tready, !s_tready, "item accepted while another in flight")
    `IAF_ASSERT_NOW(a_level_range, aclk, aresetn,
        m_tvalid, m_tdata[28:13] <= FADE_FULL, "fade level above full scale")
    `IAF_ASSERT_NOW(a_offset_range, aclk, aresetn,
        m_tvalid, $signed(m_tdata[12:0]) >= -13'sd3840 && $signed(m_tdata[12:0]) <= 13'sd3840,
        "period offset out of range")

endmodule

>>> rtl/iaf_ctrl.sv
// ----------------------------------------------------------------------------
// iaf_ctrl
// Sequencer: accept, wave scale or retrigger clear, sweep product, serial divide, result load.
// ----------------------------------------------------------------------------
module iaf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  iaf_pkg::stat_t stat,
    output iaf_pkg::cmd_t  cmd
);
    import iaf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAG  = 3'd1;
    localparam logic [2:0] ST_PROD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) state_next = ST_MAG;
            end
            ST_MAG: begin
                if (stat.retrig) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.ld_mag = 1'b1;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.ld_prod = 1'b1;
                cnt_next    = CNT_W'(DIV_STEPS - 1);
                state_next  = stat.sweep_zero ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/iaf_dp.sv
// ----------------------------------------------------------------------------
// iaf_dp
// Channel state, wave lookup, depth/sweep scaling, restoring divider and
// result register.
// ----------------------------------------------------------------------------
module iaf_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  iaf_pkg::cmd_t                   cmd,
    output iaf_pkg::stat_t                  stat,
    input  logic                            in_opcode,
    input  logic                            in_key_released,
    input  logic [1:0]                      wave_shape,
    input  logic [3:0]                      vib_depth,
    input  logic [7:0]                      vib_sweep,
    input  logic [5:0]                      vib_rate,
    input  logic [11:0]                     fade_rate,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic signed [iaf_pkg::OFFSET_W-1:0] out_period_offset,
    output logic [iaf_pkg::LEVEL_W-1:0]     out_fade_level
);
    import iaf_pkg::*;

    logic               opcode_reg;
    logic               key_reg;
    logic [7:0]         phase_reg;
    logic [7:0]         sweep_pos_reg;
    logic [LEVEL_W-1:0] fade_vol_reg;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [PROD_W-1:0]  work_reg;
    logic [7:0]         rem_reg;
    logic               valid_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [LEVEL_W-1:0] level_reg;

    logic signed [7:0]  wave;
    logic [6:0]         wmag;
    logic [10:0]        depth_prod;
    logic [7:0]         pos;
    logic [8:0]         sweep_inc;
    logic [7:0]         sweep_pos_next;
    logic [LEVEL_W-1:0] fade_next;
    logic [PROD_W-1:0]  prod;
    logic [8:0]         trial;
    logic               q_bit;
    logic [MAG_W-1:0]   res_mag;
    logic signed [OFFSET_W-1:0] offset_next;

    assign wave       = wave_at(wave_shape, phase_reg);
    assign wmag       = wave[7] ? 7'(-wave) : wave[6:0];
    assign depth_prod = 11'(wmag) * 11'(vib_depth);

    // position clamps to the sweep length if the length shrank mid-note
    assign pos            = (sweep_pos_reg > vib_sweep) ? vib_sweep : sweep_pos_reg;
    assign sweep_inc      = {1'b0, sweep_pos_reg} + 9'd1;
    assign sweep_pos_next = (sweep_inc > {1'b0, vib_sweep}) ? vib_sweep : sweep_inc[7:0];
    assign fade_next      = (fade_vol_reg > LEVEL_W'(fade_rate)) ?
                            fade_vol_reg - LEVEL_W'(fade_rate) : '0;
    assign prod           = PROD_W'(mag_reg) * PROD_W'(pos);

    // one quotient bit per step
    assign trial = {rem_reg, work_reg[PROD_W-1]};
    assign q_bit = (trial >= {1'b0, vib_sweep});

    assign res_mag     = (vib_sweep == 8'd0) ? mag_reg : work_reg[MAG_W-1:0];
    assign offset_next = (opcode_reg == OP_RETRIG) ? '0 :
                         neg_reg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});

    assign stat.retrig     = (opcode_reg == OP_RETRIG);
    assign stat.sweep_zero = (vib_sweep == 8'd0);
    assign stat.out_free   = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            opcode_reg <= in_opcode;
            key_reg    <= in_key_released;
        end
        if (cmd.ld_mag) begin
            neg_reg <= wave[7];
            mag_reg <= {depth_prod[9:0], 2'b00};
        end
        if (cmd.ld_prod) begin
            work_reg <= prod;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= q_bit ? 8'(trial - {1'b0, vib_sweep}) : trial[7:0];
            work_reg <= {work_reg[PROD_W-2:0], q_bit};
        end
        if (cmd.ld_out) begin
            offset_reg <= offset_next;
            level_reg  <= fade_vol_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            sweep_pos_reg <= '0;
            fade_vol_reg  <= FADE_FULL;
            valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear) begin
                phase_reg     <= '0;
                sweep_pos_reg <= '0;
                fade_vol_reg  <= FADE_FULL;
            end else if (cmd.ld_prod) begin
                phase_reg     <= phase_reg + {2'b00, vib_rate};
                sweep_pos_reg <= sweep_pos_next;
                if (key_reg) fade_vol_reg <= fade_next;
            end
            if (cmd.ld_out) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid          = valid_reg;
    assign out_period_offset = offset_reg;
    assign out_fade_level    = level_reg;

endmodule
